// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked implication checks, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ----- hw/rtl/msrd_pkg.sv -----
// ----------------------------------------------------------------------------
// msrd_pkg
// Types and constants shared by the multi-stack round-robin drain.
// ----------------------------------------------------------------------------
package msrd_pkg;

   localparam int QID_W       = 3;
   localparam int SLOT_IDX_W  = 10;
   localparam int VALUE_W     = 32;
   localparam int CFG_W       = 4;
   localparam int REQ_TUSER_W = 2;
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 72;

   localparam logic [CFG_W-1:0]   CFG_RESET = 4'd8;
   localparam logic [VALUE_W-1:0] DROP_MAX  = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      ACT_PUSH   = 2'd0,
      ACT_POP    = 2'd1,
      ACT_UPDATE = 2'd2,
      ACT_NOP    = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_EVAL,
      ST_ENTRY,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic               pop_valid;
      logic [VALUE_W-1:0] pop_value;
      logic               push_dropped;
      logic               update_ignored;
      logic               all_empty;
      logic [VALUE_W-1:0] drop_count;
   } rsp_type;

endpackage

// ----- hw/rtl/msrd_ram.sv -----
// ----------------------------------------------------------------------------
// msrd_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module msrd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/msrd_fill_table.sv -----
// ----------------------------------------------------------------------------
// msrd_fill_table
// Per-stack fill levels in RAM; valid bits make unwritten entries read zero.
// ----------------------------------------------------------------------------
module msrd_fill_table #(
   parameter int IDX_W = 3,
   parameter int LVL_W = 11
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] rd_idx,
   output logic [LVL_W-1:0] rd_lvl,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_idx,
   input  logic [LVL_W-1:0] wr_lvl
);

   localparam int ENTRIES = 2 ** IDX_W;

   logic [ENTRIES-1:0] vld_ff;
   logic               rd_vld_ff;
   logic [LVL_W-1:0]   ram_rd_data;

   msrd_ram #(
      .WIDTH (LVL_W),
      .DEPTH (ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_idx),
      .wr_data (wr_lvl),
      .rd_addr (rd_idx),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_idx] <= 1'b1;
         end
         rd_vld_ff <= vld_ff[rd_idx];
      end
   end

   assign rd_lvl = rd_vld_ff ? ram_rd_data : '0;

endmodule

// ----- hw/rtl/msrd_rsp_reg.sv -----
// ----------------------------------------------------------------------------
// msrd_rsp_reg
// Output register for result transfers; packs the result into tdata.
// ----------------------------------------------------------------------------
module msrd_rsp_reg
   import msrd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  rsp_type                load_data,
   output logic                   free,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // pop_valid, pop_value, push_dropped, update_ignored, all_empty, drop_count
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   assign free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {4'b0000, data_ff.drop_count, data_ff.all_empty,
                        data_ff.update_ignored, data_ff.push_dropped,
                        data_ff.pop_value, data_ff.pop_valid};

endmodule

// ----- hw/rtl/multi_stack_round_robin_drain.sv -----
// Push and update pass through lookup and evaluate to the result register; no-op goes direct.
// Pop scans from the cursor, discarding dead (zero) entries and moving on from empty stacks,
// giving up after all active stacks, or at once with no active stack; one RAM entry per cycle.
// One item at a time: the next request is taken the cycle after the result loads,
// and the result waits in the done state while the output register is not free.
// Reset clears fill valid bits, cursor and drop counter and sets the empty flag; stack RAM is kept.
// ----------------------------------------------------------------------------
// multi_stack_round_robin_drain
// Bounded LIFO stacks in RAM, drained round-robin with dead-entry skipping.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module multi_stack_round_robin_drain
   import msrd_pkg::*;
#(
   parameter int NUM_STACKS  = 8,
   parameter int STACK_DEPTH = 1024,
   parameter int ENTRY_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CFG_W-1:0]       csr_wr_data,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // queue_id, slot_index, entry_value
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // action
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // pop_valid, pop_value, push_dropped, update_ignored, all_empty, drop_count
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int CUR_W       = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
   localparam int CNT_W       = $clog2(NUM_STACKS + 1);
   localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
   localparam int SLOT_W      = $clog2(STACK_DEPTH);
   localparam int CMP_W       = (LVL_W > SLOT_IDX_W) ? LVL_W : SLOT_IDX_W;
   localparam int SADDR_W     = CUR_W + SLOT_W;
   localparam int STACK_WORDS = 2 ** SADDR_W;

   state_type              state_ff, state_in;
   action_type             act_ff, act_in;
   logic [CUR_W-1:0]       qidx_ff, qidx_in;
   logic                   q_ok_ff, q_ok_in;
   logic [CMP_W-1:0]       slot_ff, slot_in;
   logic [ENTRY_WIDTH-1:0] val_ff, val_in;
   logic [CNT_W-1:0]       n_ff, n_in;
   logic [CNT_W-1:0]       tries_ff, tries_in;
   logic [CUR_W-1:0]       cursor_ff, cursor_in;
   logic [LVL_W-1:0]       lvl_ff, lvl_in;
   logic                   empty_ff, empty_in;
   logic [VALUE_W-1:0]     drop_ff, drop_in;
   logic [CFG_W-1:0]       cfg_ff;
   logic                   pv_ff, pv_in;
   logic [VALUE_W-1:0]     pval_ff, pval_in;
   logic                   dropped_ff, dropped_in;
   logic                   ignored_ff, ignored_in;

   logic                   req_xfer;
   logic [7:0]             cfg_x, n_cap, q_x, cur_x;
   logic [CNT_W-1:0]       n_now;
   logic [CNT_W-1:0]       cur_inc;
   logic [CNT_W-1:0]       tries_nx;
   logic                   scan_over;
   logic                   lvl_zero;
   logic [LVL_W-1:0]       lvl_cur;
   logic [LVL_W-1:0]       lvl_dec;
   logic                   push_ok;
   logic                   update_ok;
   logic                   entry_live;
   logic                   pop_lookup;

   logic                   fill_wr_en;
   logic [CUR_W-1:0]       fill_idx;
   logic [LVL_W-1:0]       fill_rd_lvl;
   logic [LVL_W-1:0]       fill_wr_lvl;
   logic                   stack_wr_en;
   logic [SADDR_W-1:0]     stack_wr_addr;
   logic [SADDR_W-1:0]     stack_rd_addr;
   logic [ENTRY_WIDTH-1:0] stack_rd_data;

   logic                   rsp_free;
   logic                   rsp_load;
   rsp_type                rsp_data;

   msrd_fill_table #(
      .IDX_W (CUR_W),
      .LVL_W (LVL_W)
   ) u_fill (
      .clock  (clock),
      .reset  (reset),
      .rd_idx (fill_idx),
      .rd_lvl (fill_rd_lvl),
      .wr_en  (fill_wr_en),
      .wr_idx (fill_idx),
      .wr_lvl (fill_wr_lvl)
   );

   msrd_ram #(
      .WIDTH (ENTRY_WIDTH),
      .DEPTH (STACK_WORDS)
   ) u_stack (
      .clock   (clock),
      .wr_en   (stack_wr_en),
      .wr_addr (stack_wr_addr),
      .wr_data (val_ff),
      .rd_addr (stack_rd_addr),
      .rd_data (stack_rd_data)
   );

   msrd_rsp_reg u_rsp (
      .clock      (clock),
      .reset      (reset),
      .load       (rsp_load),
      .load_data  (rsp_data),
      .free       (rsp_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;

   assign cfg_x = 8'(cfg_ff);
   assign n_cap = (cfg_x > 8'(NUM_STACKS)) ? 8'(NUM_STACKS) : cfg_x;
   assign n_now = n_cap[CNT_W-1:0];
   assign q_x   = 8'(req_tdata[QID_W-1:0]);
   assign cur_x = 8'(cursor_ff);

   assign cur_inc    = CNT_W'(cursor_ff) + 1'b1;
   assign tries_nx   = tries_ff + 1'b1;
   assign scan_over  = (tries_nx == n_ff);
   assign lvl_cur    = (state_ff == ST_EVAL) ? fill_rd_lvl : lvl_ff;
   assign lvl_zero   = (lvl_cur == '0);
   assign lvl_dec    = lvl_cur - 1'b1;
   assign push_ok    = q_ok_ff && (fill_rd_lvl < LVL_W'(STACK_DEPTH));
   assign update_ok  = q_ok_ff && (slot_ff < CMP_W'(fill_rd_lvl));
   assign entry_live = (stack_rd_data != '0);
   assign fill_idx   = (act_ff == ACT_POP) ? cursor_ff : qidx_ff;
   assign pop_lookup = (state_ff == ST_LOOKUP) && (act_ff == ACT_POP);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               case (action_type'(req_tuser))
                  ACT_NOP: state_in = ST_DONE;
                  ACT_POP: state_in = (n_now == '0) ? ST_DONE : ST_LOOKUP;
                  default: state_in = ST_LOOKUP;
               endcase
            end
         end
         ST_LOOKUP: state_in = ST_EVAL;
         ST_EVAL: begin
            if (act_ff != ACT_POP) begin
               state_in = ST_DONE;
            end else if (!lvl_zero) begin
               state_in = ST_ENTRY;
            end else begin
               state_in = scan_over ? ST_DONE : ST_LOOKUP;
            end
         end
         ST_ENTRY: begin
            if (entry_live) begin
               state_in = ST_DONE;
            end else if (lvl_zero) begin
               state_in = scan_over ? ST_DONE : ST_LOOKUP;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      act_in        = act_ff;
      qidx_in       = qidx_ff;
      q_ok_in       = q_ok_ff;
      slot_in       = slot_ff;
      val_in        = val_ff;
      n_in          = n_ff;
      tries_in      = tries_ff;
      cursor_in     = cursor_ff;
      lvl_in        = lvl_ff;
      empty_in      = empty_ff;
      drop_in       = drop_ff;
      pv_in         = pv_ff;
      pval_in       = pval_ff;
      dropped_in    = dropped_ff;
      ignored_in    = ignored_ff;
      fill_wr_en    = 1'b0;
      fill_wr_lvl   = lvl_dec;
      stack_wr_en   = 1'b0;
      stack_wr_addr = {qidx_ff, fill_rd_lvl[SLOT_W-1:0]};
      stack_rd_addr = {cursor_ff, lvl_dec[SLOT_W-1:0]};
      rsp_load      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               act_in     = action_type'(req_tuser);
               qidx_in    = q_x[CUR_W-1:0];
               q_ok_in    = (q_x < n_cap);
               slot_in    = CMP_W'(req_tdata[QID_W +: SLOT_IDX_W]);
               val_in     = ENTRY_WIDTH'(req_tdata[QID_W + SLOT_IDX_W +: VALUE_W]);
               n_in       = n_now;
               tries_in   = '0;
               pv_in      = 1'b0;
               pval_in    = '0;
               dropped_in = 1'b0;
               ignored_in = 1'b0;
               if (action_type'(req_tuser) == ACT_POP) begin
                  if (cur_x >= n_cap) begin
                     cursor_in = '0;
                  end
                  if (n_now == '0) begin
                     empty_in = 1'b1;
                  end
               end
            end
         end
         ST_EVAL: begin
            case (act_ff)
               ACT_PUSH: begin
                  if (push_ok) begin
                     stack_wr_en = 1'b1;
                     fill_wr_en  = 1'b1;
                     fill_wr_lvl = fill_rd_lvl + 1'b1;
                     empty_in    = 1'b0;
                  end else begin
                     dropped_in = 1'b1;
                     if (drop_ff != DROP_MAX) begin
                        drop_in = drop_ff + 1'b1;
                     end
                  end
               end
               ACT_UPDATE: begin
                  stack_wr_addr = {qidx_ff, slot_ff[SLOT_W-1:0]};
                  if (update_ok) begin
                     stack_wr_en = 1'b1;
                  end else begin
                     ignored_in = 1'b1;
                  end
               end
               ACT_POP: begin
                  if (!lvl_zero) begin
                     fill_wr_en = 1'b1;
                     lvl_in     = lvl_dec;
                  end else begin
                     tries_in  = tries_nx;
                     cursor_in = (cur_inc == n_ff) ? '0 : cur_inc[CUR_W-1:0];
                     if (scan_over) begin
                        empty_in = 1'b1;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         ST_ENTRY: begin
            if (entry_live) begin
               pv_in   = 1'b1;
               pval_in = VALUE_W'(stack_rd_data);
            end else if (!lvl_zero) begin
               fill_wr_en = 1'b1;
               lvl_in     = lvl_dec;
            end else begin
               tries_in  = tries_nx;
               cursor_in = (cur_inc == n_ff) ? '0 : cur_inc[CUR_W-1:0];
               if (scan_over) begin
                  empty_in = 1'b1;
               end
            end
         end
         ST_DONE: begin
            rsp_load = rsp_free;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_data.pop_valid      = pv_ff;
      rsp_data.pop_value      = pval_ff;
      rsp_data.push_dropped   = dropped_ff;
      rsp_data.update_ignored = ignored_ff;
      rsp_data.all_empty      = empty_ff;
      rsp_data.drop_count     = drop_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cursor_ff <= '0;
         empty_ff  <= 1'b1;
         drop_ff   <= '0;
         cfg_ff    <= CFG_RESET;
         tries_ff  <= '0;
         n_ff      <= '0;
         act_ff    <= ACT_NOP;
      end else begin
         state_ff  <= state_in;
         cursor_ff <= cursor_in;
         empty_ff  <= empty_in;
         drop_ff   <= drop_in;
         tries_ff  <= tries_in;
         n_ff      <= n_in;
         act_ff    <= act_in;
         if (csr_wr_en) begin
            cfg_ff <= csr_wr_data;
         end
      end
      qidx_ff    <= qidx_in;
      q_ok_ff    <= q_ok_in;
      slot_ff    <= slot_in;
      val_ff     <= val_in;
      lvl_ff     <= lvl_in;
      pv_ff      <= pv_in;
      pval_ff    <= pval_in;
      dropped_ff <= dropped_in;
      ignored_ff <= ignored_in;
   end

   `ASSERT_IMPLIES(a_found_nonzero, clock, reset, (state_ff == ST_DONE) && pv_ff, pval_ff != '0)
   `ASSERT_IMPLIES(a_scan_bound, clock, reset, pop_lookup, tries_ff < n_ff)
   `ASSERT_NEXT(a_drop_monotone, clock, reset, 1'b1, drop_ff >= $past(drop_ff))

endmodule
